// ----- rtl/core/lpb_pkg.sv -----
// Shared types, codes and small arithmetic helpers of the layer pixel blend unit.
// Depends on nothing; the top level, lpb_csr and lpb_channel import it.
`timescale 1ns / 1ps

package lpb_pkg;

   // Number of register stages from the input register to the output register.
   localparam int NUM_STAGES = 9;

   // Unit-scaled 16-bit channel value that stands for 1.0.
   localparam logic [16:0] UNIT = 17'd65535;

   // Largest 8-bit channel or alpha value.
   localparam logic [7:0] CHAN_MAX = 8'd255;

   // Opacity in Q8 that stands for fully opaque.
   localparam logic [8:0] OPACITY_FULL = 9'd256;

   // Blend mode codes.
   localparam logic [3:0] MODE_NORMAL     = 4'd0;
   localparam logic [3:0] MODE_MULTIPLY   = 4'd1;
   localparam logic [3:0] MODE_SCREEN     = 4'd2;
   localparam logic [3:0] MODE_OVERLAY    = 4'd3;
   localparam logic [3:0] MODE_SOFT       = 4'd4;
   localparam logic [3:0] MODE_HARD       = 4'd5;
   localparam logic [3:0] MODE_DIFFERENCE = 4'd6;
   localparam logic [3:0] MODE_EXCLUSION  = 4'd7;
   localparam logic [3:0] MODE_DARKEN     = 4'd8;
   localparam logic [3:0] MODE_LIGHTEN    = 4'd9;
   localparam logic [3:0] MODE_DODGE      = 4'd10;
   localparam logic [3:0] MODE_BURN       = 4'd11;
   localparam logic [3:0] MODE_ADD        = 4'd12;
   localparam logic [3:0] MODE_SUBTRACT   = 4'd13;
   localparam logic [3:0] MODE_DIVIDE     = 4'd14;

   // Register indexes of the configuration port.
   localparam logic [1:0] REG_MODE_SEL      = 2'd0;
   localparam logic [1:0] REG_LAYER_OPACITY = 2'd1;
   localparam logic [1:0] REG_LAYER_ENABLE  = 2'd2;

   // Configuration register contents.
   typedef struct packed {
      logic [3:0] mode_sel;
      logic [8:0] layer_opacity;
      logic       layer_enable;
   } csr_type;

   // One request: destination pixel and source layer pixel.
   typedef struct packed {
      logic [7:0] dst_red;
      logic [7:0] dst_green;
      logic [7:0] dst_blue;
      logic [7:0] dst_alpha;
      logic [7:0] src_red;
      logic [7:0] src_green;
      logic [7:0] src_blue;
      logic [7:0] src_alpha;
   } pixel_pair_type;

   // One result pixel.
   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] out_alpha;
      logic       pixel_changed;
   } result_type;

   // Truncating division by 255 for values up to 255*255.
   // x = 255*hi + (lo + hi), and lo + hi stays below twice 255.
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [7:0] q0;
      logic [8:0] r;
      q0 = x[15:8];
      r  = {1'b0, x[7:0]} + {1'b0, q0};
      return q0 + {7'd0, (r >= {1'b0, CHAN_MAX})};
   endfunction

endpackage

// ----- rtl/core/lpb_channels_if.sv -----
// Handshake channels of the layer pixel blend unit: request and result.
// Standalone; carries valid, ready and the payload fields.
`timescale 1ns / 1ps

interface lpb_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] dst_red;
   logic [7:0] dst_green;
   logic [7:0] dst_blue;
   logic [7:0] dst_alpha;
   logic [7:0] src_red;
   logic [7:0] src_green;
   logic [7:0] src_blue;
   logic [7:0] src_alpha;

   modport source (output valid, dst_red, dst_green, dst_blue, dst_alpha,
                   src_red, src_green, src_blue, src_alpha, input ready);
   modport sink (input valid, dst_red, dst_green, dst_blue, dst_alpha,
                 src_red, src_green, src_blue, src_alpha, output ready);
endinterface

interface lpb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_red;
   logic [7:0] out_green;
   logic [7:0] out_blue;
   logic [7:0] out_alpha;
   logic       pixel_changed;

   modport source (output valid, out_red, out_green, out_blue, out_alpha,
                   pixel_changed, input ready);
   modport sink (input valid, out_red, out_green, out_blue, out_alpha,
                 pixel_changed, output ready);
endinterface

// ----- rtl/core/layer_pixel_blend_unit.sv -----
// The layer pixel blend unit accepts one request per clock while the result
// side keeps up and presents each composited pixel on the result channel from
// its output register, once the request has passed through every stage.
// Throughput is one pixel per cycle unless stalled, with no dependence on blend
// mode; the nine-stage depth is set by the sixteen-step divider for dodge, burn
// and divide, spread over four stages, and by the multiply and reduce chain of
// soft light. Stalls at the result side fill empty stages first, so the request
// side keeps accepting while bubbles remain. Write configuration only while the
// pipeline is empty. Depends on lpb_pkg, lpb_channels_if, lpb_csr and lpb_channel.
`timescale 1ns / 1ps

module layer_pixel_blend_unit (
   input  logic          clock,
   input  logic          reset,
   lpb_req_if.sink       req_bus,
   lpb_rsp_if.source     rsp_bus,
   input  logic          psel,
   input  logic          penable,
   input  logic          pwrite,
   input  logic [3:0]    paddr,
   input  logic [31:0]   pwdata,
   output logic [31:0]   prdata,
   output logic          pready
);
   import lpb_pkg::*;

   csr_type csr;

   lpb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .csr     (csr)
   );

   // Stage advance: a stage loads when it is empty or the next one loads.
   logic [NUM_STAGES:1] valid_ff, valid_in, adv;

   always_comb begin
      adv[NUM_STAGES] = !valid_ff[NUM_STAGES] || rsp_bus.ready;
      for (int k = NUM_STAGES - 1; k >= 1; k--) begin
         adv[k] = !valid_ff[k] || adv[k + 1];
      end
      valid_in[1] = adv[1] ? req_bus.valid : valid_ff[1];
      for (int k = 2; k <= NUM_STAGES; k++) begin
         valid_in[k] = adv[k] ? valid_ff[k - 1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_bus.ready = adv[1];

   // Stage 1: input register.
   pixel_pair_type in_ff;

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         in_ff.dst_red   <= req_bus.dst_red;
         in_ff.dst_green <= req_bus.dst_green;
         in_ff.dst_blue  <= req_bus.dst_blue;
         in_ff.dst_alpha <= req_bus.dst_alpha;
         in_ff.src_red   <= req_bus.src_red;
         in_ff.src_green <= req_bus.src_green;
         in_ff.src_blue  <= req_bus.src_blue;
         in_ff.src_alpha <= req_bus.src_alpha;
      end
   end

   // Stage 2: effective alpha and path flags.
   logic [8:0]  op_sat;
   logic [16:0] a_prod;
   logic [7:0]  a_in;
   logic        pass_in, copy_in;

   always_comb begin
      op_sat  = (csr.layer_opacity > OPACITY_FULL) ? OPACITY_FULL : csr.layer_opacity;
      a_prod  = 17'(in_ff.src_alpha) * 17'(op_sat);
      a_in    = a_prod[15:8];
      pass_in = !csr.layer_enable || (a_in == 8'd0);
      copy_in = !pass_in && (csr.mode_sel == MODE_NORMAL) && (a_in == CHAN_MAX);
   end

   // Pixel, alpha and flags travel alongside the channel pipelines.
   pixel_pair_type pp_ff [2:NUM_STAGES-1];
   logic [7:0]     a_ff [2:NUM_STAGES-1];
   logic           pass_ff [2:NUM_STAGES-1];
   logic           copy_ff [2:NUM_STAGES-1];

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         pp_ff[2]   <= in_ff;
         a_ff[2]    <= a_in;
         pass_ff[2] <= pass_in;
         copy_ff[2] <= copy_in;
      end
      for (int k = 3; k <= NUM_STAGES - 1; k++) begin
         if (adv[k]) begin
            pp_ff[k]   <= pp_ff[k - 1];
            a_ff[k]    <= a_ff[k - 1];
            pass_ff[k] <= pass_ff[k - 1];
            copy_ff[k] <= copy_ff[k - 1];
         end
      end
   end

   // Color channel pipelines.
   logic [7:0] mix_red, mix_green, mix_blue;

   lpb_channel u_red (
      .clock      (clock),
      .adv        (adv),
      .mode_sel   (csr.mode_sel),
      .dst_s1     (in_ff.dst_red),
      .src_s1     (in_ff.src_red),
      .alpha_s7   (a_ff[7]),
      .mix_out    (mix_red)
   );

   lpb_channel u_green (
      .clock      (clock),
      .adv        (adv),
      .mode_sel   (csr.mode_sel),
      .dst_s1     (in_ff.dst_green),
      .src_s1     (in_ff.src_green),
      .alpha_s7   (a_ff[7]),
      .mix_out    (mix_green)
   );

   lpb_channel u_blue (
      .clock      (clock),
      .adv        (adv),
      .mode_sel   (csr.mode_sel),
      .dst_s1     (in_ff.dst_blue),
      .src_s1     (in_ff.src_blue),
      .alpha_s7   (a_ff[7]),
      .mix_out    (mix_blue)
   );

   // Stage 8: source-over alpha products.
   logic [15:0] asum_ff, asum_in;

   assign asum_in = 16'(a_ff[7]) * 16'(CHAN_MAX)
                  + 16'(pp_ff[7].dst_alpha) * 16'(CHAN_MAX - a_ff[7]);

   always_ff @(posedge clock) begin
      if (adv[8]) begin
         asum_ff <= asum_in;
      end
   end

   // Stage 9: result select into the output register.
   result_type out_ff, out_in;

   always_comb begin
      if (pass_ff[8]) begin
         out_in.out_red       = pp_ff[8].dst_red;
         out_in.out_green     = pp_ff[8].dst_green;
         out_in.out_blue      = pp_ff[8].dst_blue;
         out_in.out_alpha     = pp_ff[8].dst_alpha;
         out_in.pixel_changed = 1'b0;
      end else if (copy_ff[8]) begin
         out_in.out_red       = pp_ff[8].src_red;
         out_in.out_green     = pp_ff[8].src_green;
         out_in.out_blue      = pp_ff[8].src_blue;
         out_in.out_alpha     = CHAN_MAX;
         out_in.pixel_changed = 1'b1;
      end else begin
         out_in.out_red       = mix_red;
         out_in.out_green     = mix_green;
         out_in.out_blue      = mix_blue;
         out_in.out_alpha     = div255(asum_ff);
         out_in.pixel_changed = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[9]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_bus.valid         = valid_ff[NUM_STAGES];
   assign rsp_bus.out_red       = out_ff.out_red;
   assign rsp_bus.out_green     = out_ff.out_green;
   assign rsp_bus.out_blue      = out_ff.out_blue;
   assign rsp_bus.out_alpha     = out_ff.out_alpha;
   assign rsp_bus.pixel_changed = out_ff.pixel_changed;

   // The pipeline is empty in the cycle after reset.
   assert property (@(posedge clock) $past(reset) |-> (valid_ff == '0))
      else $error("pipeline not empty after reset");

   // An accepted request is held in the input stage on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> valid_ff[1])
      else $error("accepted request lost at input stage");

   // Pass-through and full-alpha copy never apply to the same pixel.
   assert property (@(posedge clock) disable iff (reset)
      valid_ff[8] |-> !(pass_ff[8] && copy_ff[8]))
      else $error("pass-through and copy both flagged");

   // A waiting result stays in the output stage until taken.
   assert property (@(posedge clock) disable iff (reset)
      (valid_ff[9] && !rsp_bus.ready) |=> (valid_ff[9] && $stable(out_ff)))
      else $error("waiting result dropped or changed");

endmodule

// ----- rtl/core/lpb_csr.sv -----
// APB-style configuration registers of the layer pixel blend unit.
// Depends on lpb_pkg for register codes and the csr_type struct.
`timescale 1ns / 1ps

module lpb_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [3:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready,
   output lpb_pkg::csr_type    csr
);
   import lpb_pkg::*;

   logic [3:0] mode_ff, mode_in;
   logic [8:0] opacity_ff, opacity_in;
   logic       enable_ff, enable_in;
   logic       wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   // Register write decode.
   always_comb begin
      mode_in    = mode_ff;
      opacity_in = opacity_ff;
      enable_in  = enable_ff;
      if (wr_en) begin
         unique case (paddr[3:2])
            REG_MODE_SEL:      mode_in    = pwdata[3:0];
            REG_LAYER_OPACITY: opacity_in = pwdata[8:0];
            REG_LAYER_ENABLE:  enable_in  = pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_NORMAL;
         opacity_ff <= OPACITY_FULL;
         enable_ff  <= 1'b1;
      end else begin
         mode_ff    <= mode_in;
         opacity_ff <= opacity_in;
         enable_ff  <= enable_in;
      end
   end

   // Read back.
   always_comb begin
      unique case (paddr[3:2])
         REG_MODE_SEL:      prdata = {28'd0, mode_ff};
         REG_LAYER_OPACITY: prdata = {23'd0, opacity_ff};
         REG_LAYER_ENABLE:  prdata = {31'd0, enable_ff};
         default:           prdata = 32'd0;
      endcase
   end

   assign csr.mode_sel      = mode_ff;
   assign csr.layer_opacity = opacity_ff;
   assign csr.layer_enable  = enable_ff;

endmodule

// ----- rtl/core/lpb_channel.sv -----
// Blend pipeline for one color channel: mode math, divider, clamp and alpha mix.
// Depends on lpb_pkg; stage loads are driven by the top level's advance vector.
`timescale 1ns / 1ps

module lpb_channel (
   input  logic                          clock,
   input  logic [lpb_pkg::NUM_STAGES:1]  adv,
   input  logic [3:0]                    mode_sel,
   input  logic [7:0]                    dst_s1,
   input  logic [7:0]                    src_s1,
   input  logic [7:0]                    alpha_s7,
   output logic [7:0]                    mix_out
);
   import lpb_pkg::*;

   localparam logic signed [18:0] UNIT_R = 19'sd65535;

   // Divider state: partial remainder, numerator bits being replaced by quotient bits.
   typedef struct packed {
      logic [7:0]  rem;
      logic [15:0] nq;
      logic [7:0]  den;
      logic        sat;
      logic        guard;
      logic        gval;
   } div_type;

   // Truncating division by 65535 for values below 2**33.
   function automatic logic [17:0] div_unit(input logic [33:0] x);
      logic [17:0] q0;
      logic [18:0] r;
      logic [2:0]  q1;
      logic [16:0] r2;
      q0 = x[33:16];
      r  = {3'd0, x[15:0]} + {1'b0, q0};
      q1 = r[18:16];
      r2 = {1'b0, r[15:0]} + {14'd0, q1};
      return q0 + {15'd0, q1} + {17'd0, (r2 >= UNIT)};
   endfunction

   // Truncating division by 257 for 16-bit values.
   function automatic logic [7:0] div257(input logic [15:0] r);
      logic [7:0] q0;
      q0 = r[15:8];
      return (r[7:0] < q0) ? q0 - 8'd1 : q0;
   endfunction

   // Four restoring division steps.
   function automatic div_type div4(input div_type dv);
      div_type    o;
      logic [8:0] t;
      o = dv;
      for (int i = 0; i < 4; i++) begin
         t = {o.rem, o.nq[15]};
         if (t >= {1'b0, o.den}) begin
            o.rem = 8'(t - {1'b0, o.den});
            o.nq  = {o.nq[14:0], 1'b1};
         end else begin
            o.rem = t[7:0];
            o.nq  = {o.nq[14:0], 1'b0};
         end
      end
      return o;
   endfunction

   // ---------------- Stage 2: products and divider setup ----------------
   logic [16:0]        d1, s1, dn1, sn1, x2;
   logic [15:0]        y2;
   logic               inv2_in;
   logic [7:0]         num_hi, den2;
   logic [23:0]        num2;
   div_type            dv2_in;
   logic [7:0]         dst2_ff, src2_ff;
   logic [32:0]        p2_ff, p2_in;
   logic [31:0]        pdd2_ff, pdd2_in;
   logic signed [17:0] f2_ff, f2_in;
   logic               inv2_ff;
   div_type            dv2_ff;

   always_comb begin
      d1  = {1'b0, dst_s1, dst_s1};
      s1  = {1'b0, src_s1, src_s1};
      dn1 = UNIT - d1;
      sn1 = UNIT - s1;
      x2      = 17'd0;
      y2      = 16'd0;
      inv2_in = 1'b0;
      case (mode_sel)
         MODE_MULTIPLY: begin
            x2 = d1;
            y2 = s1[15:0];
         end
         MODE_SCREEN: begin
            x2      = dn1;
            y2      = sn1[15:0];
            inv2_in = 1'b1;
         end
         MODE_OVERLAY: begin
            if ({d1[15:0], 1'b0} < UNIT) begin
               x2 = {d1[15:0], 1'b0};
               y2 = s1[15:0];
            end else begin
               x2      = {dn1[15:0], 1'b0};
               y2      = sn1[15:0];
               inv2_in = 1'b1;
            end
         end
         MODE_HARD: begin
            if ({s1[15:0], 1'b0} < UNIT) begin
               x2 = {d1[15:0], 1'b0};
               y2 = s1[15:0];
            end else begin
               x2      = {dn1[15:0], 1'b0};
               y2      = sn1[15:0];
               inv2_in = 1'b1;
            end
         end
         MODE_EXCLUSION: begin
            x2 = {d1[15:0], 1'b0};
            y2 = s1[15:0];
         end
         default: ;
      endcase
      p2_in   = 33'(x2) * 33'(y2);
      pdd2_in = 32'(d1[15:0]) * 32'(d1[15:0]);
      f2_in   = $signed({1'b0, s1[15:0], 1'b0}) - $signed({1'b0, UNIT});

      // Dodge, burn and divide reduce to an 8-bit divisor since both scales are 257.
      num_hi       = 8'd0;
      den2         = 8'd1;
      dv2_in.guard = 1'b0;
      dv2_in.gval  = 1'b0;
      case (mode_sel)
         MODE_DODGE: begin
            num_hi       = dst_s1;
            den2         = CHAN_MAX - src_s1;
            dv2_in.guard = (src_s1 == CHAN_MAX);
            dv2_in.gval  = (dst_s1 != 8'd0);
         end
         MODE_BURN: begin
            num_hi       = CHAN_MAX - dst_s1;
            den2         = src_s1;
            dv2_in.guard = (src_s1 == 8'd0);
            dv2_in.gval  = (dst_s1 == CHAN_MAX);
         end
         MODE_DIVIDE: begin
            num_hi       = dst_s1;
            den2         = src_s1;
            dv2_in.guard = (src_s1 == 8'd0);
            dv2_in.gval  = (dst_s1 != 8'd0);
         end
         default: ;
      endcase
      num2       = {num_hi, 16'd0} - {16'd0, num_hi};
      dv2_in.rem = num2[23:16];
      dv2_in.nq  = num2[15:0];
      dv2_in.den = den2;
      dv2_in.sat = (num2[23:16] >= den2);
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         dst2_ff <= dst_s1;
         src2_ff <= src_s1;
         p2_ff   <= p2_in;
         pdd2_ff <= pdd2_in;
         f2_ff   <= f2_in;
         inv2_ff <= inv2_in;
         dv2_ff  <= dv2_in;
      end
   end

   // ---------------- Stage 3: reduce products, first divider steps ----------------
   logic [17:0] m3_ff, m3_in, mdd3, e3_full;
   logic [14:0] e3_ff, e3_in;
   logic [15:0] fmag3_ff, fmag3_in;
   logic        fneg3_ff, inv3_ff;
   logic [7:0]  dst3_ff, src3_ff;
   div_type     dv3_ff, dv3_in;

   always_comb begin
      m3_in    = div_unit({1'b0, p2_ff});
      mdd3     = div_unit({2'd0, pdd2_ff});
      e3_full  = {2'd0, dst2_ff, dst2_ff} - mdd3;
      e3_in    = e3_full[14:0];
      fmag3_in = f2_ff[17] ? 16'(-f2_ff) : f2_ff[15:0];
      dv3_in   = div4(dv2_ff);
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         dst3_ff  <= dst2_ff;
         src3_ff  <= src2_ff;
         m3_ff    <= m3_in;
         e3_ff    <= e3_in;
         fmag3_ff <= fmag3_in;
         fneg3_ff <= f2_ff[17];
         inv3_ff  <= inv2_ff;
         dv3_ff   <= dv3_in;
      end
   end

   // ---------------- Stage 4: soft light product ----------------
   logic [30:0] ps4_ff, ps4_in;
   logic [17:0] m4_ff;
   logic        fneg4_ff, inv4_ff;
   logic [7:0]  dst4_ff, src4_ff;
   div_type     dv4_ff, dv4_in;

   always_comb begin
      ps4_in = 31'(fmag3_ff) * 31'(e3_ff);
      dv4_in = div4(dv3_ff);
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         dst4_ff  <= dst3_ff;
         src4_ff  <= src3_ff;
         m4_ff    <= m3_ff;
         ps4_ff   <= ps4_in;
         fneg4_ff <= fneg3_ff;
         inv4_ff  <= inv3_ff;
         dv4_ff   <= dv4_in;
      end
   end

   // ---------------- Stage 5: reduce soft light product ----------------
   // The reduced magnitude reaches 16384, so it keeps fifteen bits.
   logic [17:0]        ms5;
   logic signed [15:0] msoft5_ff, msoft5_in;
   logic [17:0]        m5_ff;
   logic               inv5_ff;
   logic [7:0]         dst5_ff, src5_ff;
   div_type            dv5_ff, dv5_in;

   always_comb begin
      ms5       = div_unit({3'd0, ps4_ff});
      msoft5_in = fneg4_ff ? -$signed({1'b0, ms5[14:0]}) : $signed({1'b0, ms5[14:0]});
      dv5_in    = div4(dv4_ff);
   end

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         dst5_ff   <= dst4_ff;
         src5_ff   <= src4_ff;
         m5_ff     <= m4_ff;
         msoft5_ff <= msoft5_in;
         inv5_ff   <= inv4_ff;
         dv5_ff    <= dv5_in;
      end
   end

   // ---------------- Stage 6: last divider steps and mode select ----------------
   div_type            dv6;
   logic signed [18:0] dr, sr, mr, qr, gr, r6_in, r6_ff;
   logic [7:0]         dst6_ff;

   always_comb begin
      dv6 = div4(dv5_ff);
      dr  = $signed({3'd0, dst5_ff, dst5_ff});
      sr  = $signed({3'd0, src5_ff, src5_ff});
      mr  = $signed({1'b0, m5_ff});
      qr  = $signed({3'd0, dv6.nq});
      gr  = dv5_ff.gval ? UNIT_R : 19'sd0;
      case (mode_sel) inside
         MODE_MULTIPLY, MODE_SCREEN, MODE_OVERLAY, MODE_HARD:
            r6_in = inv5_ff ? UNIT_R - mr : mr;
         MODE_SOFT:       r6_in = dr + 19'(msoft5_ff);
         MODE_DIFFERENCE: r6_in = (dr > sr) ? dr - sr : sr - dr;
         MODE_EXCLUSION:  r6_in = dr + sr - mr;
         MODE_DARKEN:     r6_in = (dr < sr) ? dr : sr;
         MODE_LIGHTEN:    r6_in = (dr > sr) ? dr : sr;
         MODE_DODGE, MODE_DIVIDE:
            r6_in = dv5_ff.guard ? gr : (dv5_ff.sat ? UNIT_R : qr);
         MODE_BURN:
            r6_in = dv5_ff.guard ? gr : (dv5_ff.sat ? 19'sd0 : UNIT_R - qr);
         MODE_ADD:        r6_in = dr + sr;
         MODE_SUBTRACT:   r6_in = dr - sr;
         default:         r6_in = sr;
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         dst6_ff <= dst5_ff;
         r6_ff   <= r6_in;
      end
   end

   // ---------------- Stage 7: clamp and scale to 8 bits ----------------
   logic [15:0] c7;
   logic [7:0]  b7_ff, b7_in, dst7_ff;

   always_comb begin
      if (r6_ff < 19'sd0) begin
         c7 = 16'd0;
      end else if (r6_ff > UNIT_R) begin
         c7 = UNIT[15:0];
      end else begin
         c7 = r6_ff[15:0];
      end
      b7_in = div257(c7);
   end

   always_ff @(posedge clock) begin
      if (adv[7]) begin
         dst7_ff <= dst6_ff;
         b7_ff   <= b7_in;
      end
   end

   // ---------------- Stage 8: alpha mix products ----------------
   logic [15:0] mix8_ff, mix8_in;

   assign mix8_in = 16'(b7_ff) * 16'(alpha_s7)
                  + 16'(dst7_ff) * 16'(CHAN_MAX - alpha_s7);

   always_ff @(posedge clock) begin
      if (adv[8]) begin
         mix8_ff <= mix8_in;
      end
   end

   assign mix_out = div255(mix8_ff);

endmodule
